// ===== sv/irlf_pkg.sv =====
`default_nettype none

package irlf_pkg;

	localparam int unsigned TABLE_ENTRIES = 2048;
	localparam int unsigned IDX_W = $clog2(TABLE_ENTRIES);

	localparam int unsigned CFG_W = 32;
	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned CREDIT_W = 16;
	localparam int unsigned ACCUM_W = 31;
	localparam int unsigned STAMP_W = 64;
	localparam int unsigned ELAP_W = 30;
	localparam int unsigned BUCKET_IDX_W = 11;

	localparam logic [CFG_IDX_W-1:0] REG_HASH_KEY = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CREDIT_LIMIT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_REFILL_CREDIT = 2'd2;

	localparam logic [31:0] HASH_KEY_RST = 32'd0;
	localparam logic [CREDIT_W-1:0] CREDIT_LIMIT_RST = 16'd1000;
	localparam logic [CREDIT_W-1:0] REFILL_CREDIT_RST = 16'd500;

	localparam logic [31:0] PREFIX_MASK = 32'hFFFF_FF00;
	localparam logic [STAMP_W-1:0] NS_PER_SEC = 64'd1000000000;
	localparam logic [ELAP_W-1:0] NS_PER_SEC_E = 30'd1000000000;
	localparam logic [31:0] HALF_SEC = 32'd500000000;
	localparam logic [31:0] ONE_SEC = 32'd1000000000;

	localparam logic [7:0] PROTO_ICMP = 8'd1;
	localparam logic [7:0] PROTO_UDP = 8'd17;
	localparam logic [7:0] ICMP_ECHO_REPLY = 8'd0;
	localparam logic [7:0] ICMP_UNREACHABLE = 8'd3;
	localparam logic [7:0] ICMP_REDIR = 8'd5;
	localparam logic [7:0] CODE_FRAG_NEEDED = 8'd4;

	localparam logic [2:0] REASON_UNCHECKED = 3'd0;
	localparam logic [2:0] REASON_PASSED = 3'd1;
	localparam logic [2:0] REASON_RATE_LIMITED = 3'd2;
	localparam logic [2:0] REASON_BAD_REDIRECT = 3'd3;
	localparam logic [2:0] REASON_BAD_FRAG = 3'd4;

	typedef struct packed {
		logic outer_valid;
		logic [7:0] ip_protocol;
		logic [31:0] src_addr;
		logic [7:0] icmp_type;
		logic [7:0] icmp_code;
		logic inner_ip_valid;
		logic [7:0] inner_protocol;
		logic inner_icmp_valid;
		logic [7:0] inner_icmp_type;
		logic [63:0] now_ns;
		logic [1:0] cost;
	} pkt_t;

	typedef struct packed {
		logic drop;
		logic [2:0] verdict_reason;
		logic [BUCKET_IDX_W-1:0] bucket_index;
		logic [CREDIT_W-1:0] credit_left;
	} verdict_t;

	typedef struct packed {
		logic used;
		logic [CREDIT_W-1:0] credit;
		logic [ACCUM_W-1:0] accum;
		logic [STAMP_W-1:0] stamp;
	} bucket_t;

endpackage

`default_nettype wire

// ===== sv/irlf_bucket_ram.sv =====
`default_nettype none

module irlf_bucket_ram
	import irlf_pkg::*;
(
	input wire logic clk,
	input wire logic we,
	input wire logic [IDX_W-1:0] waddr,
	input wire bucket_t wdata,
	input wire logic re,
	input wire logic [IDX_W-1:0] raddr,
	output bucket_t rdata
);

	bucket_t mem [TABLE_ENTRIES];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== sv/irlf_bucket_calc.sv =====
`default_nettype none

module irlf_bucket_calc
	import irlf_pkg::*;
(
	input wire logic clk,
	input wire bucket_t rd,
	input wire logic [STAMP_W-1:0] now_ns,
	input wire logic [CREDIT_W-1:0] credit_limit,
	input wire logic [CREDIT_W-1:0] refill_credit,
	output logic [CREDIT_W-1:0] credit_s3,
	output logic [ACCUM_W-1:0] accum_s3
);

	logic [STAMP_W-1:0] stamp;
	logic [STAMP_W-1:0] elapsed;
	logic [ELAP_W-1:0] elap_cap;
	logic [ELAP_W-1:0] elap_s1;
	logic [CREDIT_W-1:0] credit_s1;
	logic [ACCUM_W-1:0] accum_s1;
	logic [31:0] sum_s2;
	logic [CREDIT_W-1:0] credit_s2;
	logic [CREDIT_W:0] refilled;
	logic [31:0] over_half;

	// a fresh bucket starts full with an empty accumulator
	always_comb begin
		stamp = rd.used ? rd.stamp : now_ns;
		elapsed = now_ns - stamp;
		elap_cap = (elapsed >= NS_PER_SEC) ? NS_PER_SEC_E : elapsed[ELAP_W-1:0];
	end

	always_ff @(posedge clk) begin
		elap_s1 <= elap_cap;
		credit_s1 <= rd.used ? rd.credit : credit_limit;
		accum_s1 <= rd.used ? rd.accum : '0;
	end

	always_ff @(posedge clk) begin
		sum_s2 <= {1'b0, accum_s1} + {2'b00, elap_s1};
		credit_s2 <= credit_s1;
	end

	always_comb begin
		refilled = {1'b0, credit_s2} + {1'b0, refill_credit};
		over_half = sum_s2 - HALF_SEC;
	end

	always_ff @(posedge clk) begin
		if (sum_s2 >= HALF_SEC) begin
			accum_s3 <= (sum_s2 >= ONE_SEC) ? HALF_SEC[ACCUM_W-1:0] : over_half[ACCUM_W-1:0];
			credit_s3 <= (refilled > {1'b0, credit_limit}) ? credit_limit
				: refilled[CREDIT_W-1:0];
		end else begin
			accum_s3 <= sum_s2[ACCUM_W-1:0];
			credit_s3 <= credit_s2;
		end
	end

endmodule

`default_nettype wire

// ===== sv/icmp_rate_limit_filter.sv =====
// an item passes states RD, EL, AC, FIN to its verdict in the output register,
// FIN holding while a pending verdict is not taken; items go one at a time,
// each a read-modify-write of the bucket memory (read, three arithmetic
// stages, write back); reset: after arst_n rises a clearing pass marks every
// bucket unused; only configuration writes are taken until it ends
`default_nettype none

module icmp_rate_limit_filter
	import irlf_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic pkt_valid,
	output logic pkt_ready,
	input wire pkt_t pkt,
	output logic verdict_valid,
	input wire logic verdict_ready,
	output verdict_t verdict,
	input wire logic cfg_we,
	input wire logic [CFG_IDX_W-1:0] cfg_idx,
	input wire logic [CFG_W-1:0] cfg_wdata
);

	localparam logic [2:0] ST_CLEAR = 3'd0;
	localparam logic [2:0] ST_IDLE = 3'd1;
	localparam logic [2:0] ST_RD = 3'd2;
	localparam logic [2:0] ST_EL = 3'd3;
	localparam logic [2:0] ST_AC = 3'd4;
	localparam logic [2:0] ST_FIN = 3'd5;

	logic [2:0] state_q;
	logic [IDX_W-1:0] clr_q;
	logic [31:0] hash_key_q;
	logic [CREDIT_W-1:0] credit_limit_q;
	logic [CREDIT_W-1:0] refill_credit_q;
	pkt_t pkt_q;
	logic [IDX_W-1:0] idx_q;
	logic unchecked_q;
	logic verdict_valid_q;
	verdict_t verdict_q;

	logic accept;
	logic finish;
	logic [31:0] hashed;
	logic [IDX_W-1:0] idx;
	logic ram_we;
	logic [IDX_W-1:0] ram_waddr;
	bucket_t ram_wdata;
	bucket_t ram_rdata;
	logic [CREDIT_W-1:0] credit_s3;
	logic [ACCUM_W-1:0] accum_s3;
	logic [CREDIT_W-1:0] cost_ext;
	logic credit_ok;
	logic [CREDIT_W-1:0] credit_new;
	logic bad_redirect;
	logic bad_frag;
	verdict_t verdict_d;

	assign pkt_ready = (state_q == ST_IDLE);
	assign accept = pkt_valid && pkt_ready;
	assign finish = (state_q == ST_FIN) && (!verdict_valid_q || verdict_ready);
	assign verdict_valid = verdict_valid_q;
	assign verdict = verdict_q;

	assign hashed = (pkt.src_addr & PREFIX_MASK) ^ hash_key_q;
	assign idx = hashed[IDX_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hash_key_q <= HASH_KEY_RST;
			credit_limit_q <= CREDIT_LIMIT_RST;
			refill_credit_q <= REFILL_CREDIT_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_HASH_KEY: hash_key_q <= cfg_wdata;
				REG_CREDIT_LIMIT: credit_limit_q <= cfg_wdata[CREDIT_W-1:0];
				REG_REFILL_CREDIT: refill_credit_q <= cfg_wdata[CREDIT_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q <= '0;
		end else begin
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == IDX_W'(TABLE_ENTRIES - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (pkt_valid) begin
						state_q <= ST_RD;
					end
				end
				ST_RD: state_q <= ST_EL;
				ST_EL: state_q <= ST_AC;
				ST_AC: state_q <= ST_FIN;
				ST_FIN: begin
					if (finish) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pkt_q <= pkt;
			idx_q <= idx;
			unchecked_q <= !pkt.outer_valid || (pkt.ip_protocol != PROTO_ICMP);
		end
	end

	irlf_bucket_ram u_ram (
		.clk(clk),
		.we(ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re(accept),
		.raddr(idx),
		.rdata(ram_rdata)
	);

	irlf_bucket_calc u_calc (
		.clk(clk),
		.rd(ram_rdata),
		.now_ns(pkt_q.now_ns),
		.credit_limit(credit_limit_q),
		.refill_credit(refill_credit_q),
		.credit_s3(credit_s3),
		.accum_s3(accum_s3)
	);

	always_comb begin
		cost_ext = {{(CREDIT_W-2){1'b0}}, pkt_q.cost};
		credit_ok = (credit_s3 >= cost_ext);
		credit_new = credit_ok ? (credit_s3 - cost_ext) : credit_s3;
		bad_redirect = pkt_q.inner_ip_valid
			&& (pkt_q.inner_protocol == PROTO_UDP || pkt_q.inner_protocol == PROTO_ICMP);
		bad_frag = pkt_q.inner_ip_valid && (pkt_q.inner_protocol == PROTO_ICMP)
			&& pkt_q.inner_icmp_valid
			&& (pkt_q.inner_icmp_type == ICMP_ECHO_REPLY
			|| pkt_q.inner_icmp_type == ICMP_UNREACHABLE
			|| pkt_q.inner_icmp_type == ICMP_REDIR);

		verdict_d.drop = 1'b0;
		verdict_d.verdict_reason = REASON_PASSED;
		verdict_d.bucket_index = BUCKET_IDX_W'(idx_q);
		verdict_d.credit_left = credit_new;
		priority if (unchecked_q) begin
			verdict_d.verdict_reason = REASON_UNCHECKED;
			verdict_d.bucket_index = '0;
			verdict_d.credit_left = '0;
		end else if (!credit_ok) begin
			verdict_d.drop = 1'b1;
			verdict_d.verdict_reason = REASON_RATE_LIMITED;
		end else if (pkt_q.icmp_type == ICMP_REDIR) begin
			if (bad_redirect) begin
				verdict_d.drop = 1'b1;
				verdict_d.verdict_reason = REASON_BAD_REDIRECT;
			end
		end else if (pkt_q.icmp_type == ICMP_UNREACHABLE
			&& pkt_q.icmp_code == CODE_FRAG_NEEDED) begin
			if (bad_frag) begin
				verdict_d.drop = 1'b1;
				verdict_d.verdict_reason = REASON_BAD_FRAG;
			end
		end else begin
			verdict_d.drop = 1'b0;
		end
	end

	// clearing pass writes unused marks, otherwise the updated bucket of a checked item goes back at finish
	always_comb begin
		if (state_q == ST_CLEAR) begin
			ram_we = 1'b1;
			ram_waddr = clr_q;
			ram_wdata.used = 1'b0;
			ram_wdata.credit = '0;
			ram_wdata.accum = '0;
			ram_wdata.stamp = '0;
		end else begin
			ram_we = finish && !unchecked_q;
			ram_waddr = idx_q;
			ram_wdata.used = 1'b1;
			ram_wdata.credit = credit_new;
			ram_wdata.accum = accum_s3;
			ram_wdata.stamp = pkt_q.now_ns;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			verdict_valid_q <= 1'b0;
		end else if (finish) begin
			verdict_valid_q <= 1'b1;
		end else if (verdict_ready) begin
			verdict_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			verdict_q <= verdict_d;
		end
	end

	a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLEAR) |-> !pkt_ready)
		else $error("item accepted during clearing pass");

	a_accept_reads: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == ST_RD))
		else $error("accepted item did not start a table read");

	a_write_only_at_finish: assert property (@(posedge clk) disable iff (!arst_n)
		(ram_we && state_q != ST_CLEAR) |-> (state_q == ST_FIN && !unchecked_q))
		else $error("bucket write outside finish of a checked item");

	a_result_per_finish: assert property (@(posedge clk) disable iff (!arst_n)
		finish |=> verdict_valid)
		else $error("finished item produced no verdict");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(verdict_valid && !verdict_ready) |-> !finish)
		else $error("pending verdict overwritten");

endmodule

`default_nettype wire

// ===== tb/icmp_rate_limit_filter_tb.sv =====
`timescale 1ns / 100ps

module icmp_rate_limit_filter_tb;
	import irlf_pkg::*;

	localparam logic [7:0] PROTO_TCP = 8'd6;
	localparam logic [7:0] ICMP_ECHO_REQUEST = 8'd8;
	localparam logic [7:0] CODE_PORT_UNREACH = 8'd3;
	localparam int POOL_SIZE = 6;

	logic clk;
	logic arst_n;
	logic pkt_valid;
	logic pkt_ready;
	pkt_t pkt;
	logic verdict_valid;
	logic verdict_ready;
	verdict_t verdict;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_idx;
	logic [CFG_W-1:0] cfg_wdata;

	// bucket table and registers as the block should hold them
	bit bkt_used [TABLE_ENTRIES];
	int unsigned bkt_credit [TABLE_ENTRIES];
	longint unsigned bkt_accum [TABLE_ENTRIES];
	longint unsigned bkt_stamp [TABLE_ENTRIES];
	logic [31:0] key_reg;
	int unsigned limit_reg;
	int unsigned refill_reg;

	verdict_t pending_verdicts [$];
	int mismatch_count;
	int send_idle_pct;
	int stall_pct;
	int hold_cycles;
	logic [23:0] src_pool [POOL_SIZE];
	logic [63:0] clock_ns;

	icmp_rate_limit_filter dut (
		.clk(clk),
		.arst_n(arst_n),
		.pkt_valid(pkt_valid),
		.pkt_ready(pkt_ready),
		.pkt(pkt),
		.verdict_valid(verdict_valid),
		.verdict_ready(verdict_ready),
		.verdict(verdict),
		.cfg_we(cfg_we),
		.cfg_idx(cfg_idx),
		.cfg_wdata(cfg_wdata)
	);

	function automatic verdict_t rate_filter_verdict(pkt_t p);
		verdict_t v;
		int unsigned idx;
		int unsigned credit;
		longint unsigned elapsed;
		longint unsigned acc;
		v = '0;
		if (!p.outer_valid || p.ip_protocol != PROTO_ICMP) begin
			v.verdict_reason = REASON_UNCHECKED;
			return v;
		end
		idx = ((p.src_addr & PREFIX_MASK) ^ key_reg) % TABLE_ENTRIES;
		if (!bkt_used[idx]) begin
			bkt_used[idx] = 1'b1;
			bkt_credit[idx] = limit_reg;
			bkt_accum[idx] = 0;
			bkt_stamp[idx] = p.now_ns;
		end
		// elapsed time wraps when the stamp goes backwards
		elapsed = p.now_ns - bkt_stamp[idx];
		acc = bkt_accum[idx] + ((elapsed < NS_PER_SEC) ? elapsed : NS_PER_SEC);
		bkt_stamp[idx] = p.now_ns;
		credit = bkt_credit[idx];
		if (acc >= HALF_SEC) begin
			acc = acc - HALF_SEC;
			if (acc > HALF_SEC)
				acc = HALF_SEC;
			credit = credit + refill_reg;
			if (credit > limit_reg)
				credit = limit_reg;
		end
		bkt_accum[idx] = acc;
		v.verdict_reason = REASON_PASSED;
		if (credit < p.cost) begin
			v.drop = 1'b1;
			v.verdict_reason = REASON_RATE_LIMITED;
		end else begin
			credit = credit - p.cost;
			if (p.icmp_type == ICMP_REDIR) begin
				if (p.inner_ip_valid &&
				    (p.inner_protocol == PROTO_UDP || p.inner_protocol == PROTO_ICMP)) begin
					v.drop = 1'b1;
					v.verdict_reason = REASON_BAD_REDIRECT;
				end
			end else if (p.icmp_type == ICMP_UNREACHABLE && p.icmp_code == CODE_FRAG_NEEDED) begin
				if (p.inner_ip_valid && p.inner_protocol == PROTO_ICMP && p.inner_icmp_valid &&
				    (p.inner_icmp_type == ICMP_ECHO_REPLY ||
				     p.inner_icmp_type == ICMP_UNREACHABLE ||
				     p.inner_icmp_type == ICMP_REDIR)) begin
					v.drop = 1'b1;
					v.verdict_reason = REASON_BAD_FRAG;
				end
			end
		end
		bkt_credit[idx] = credit & 32'hFFFF;
		v.bucket_index = idx[BUCKET_IDX_W-1:0];
		v.credit_left = credit[CREDIT_W-1:0];
		return v;
	endfunction

	function automatic pkt_t icmp_pkt(logic [31:0] src, logic [7:0] typ, logic [7:0] code,
			logic [63:0] now);
		pkt_t p;
		p = '0;
		p.outer_valid = 1'b1;
		p.ip_protocol = PROTO_ICMP;
		p.src_addr = src;
		p.icmp_type = typ;
		p.icmp_code = code;
		p.now_ns = now;
		p.cost = 2'd1;
		return p;
	endfunction

	function automatic pkt_t quoted(pkt_t p, logic ipv, logic [7:0] proto, logic icv,
			logic [7:0] ityp);
		pkt_t q;
		q = p;
		q.inner_ip_valid = ipv;
		q.inner_protocol = proto;
		q.inner_icmp_valid = icv;
		q.inner_icmp_type = ityp;
		return q;
	endfunction

	function automatic pkt_t random_icmp_pkt();
		pkt_t p;
		int unsigned r;
		p.outer_valid = ($urandom_range(99) < 92);
		p.ip_protocol = ($urandom_range(99) < 90) ? PROTO_ICMP : 8'($urandom());
		if ($urandom_range(99) < 85)
			p.src_addr = {src_pool[$urandom_range(POOL_SIZE - 1)], 8'($urandom())};
		else
			p.src_addr = $urandom();
		case ($urandom_range(5))
			0: p.icmp_type = ICMP_ECHO_REPLY;
			1, 2: p.icmp_type = ICMP_UNREACHABLE;
			3, 4: p.icmp_type = ICMP_REDIR;
			default: p.icmp_type = 8'($urandom());
		endcase
		if (p.icmp_type == ICMP_UNREACHABLE && $urandom_range(1))
			p.icmp_code = CODE_FRAG_NEEDED;
		else
			p.icmp_code = 8'($urandom());
		p.inner_ip_valid = ($urandom_range(99) < 85);
		case ($urandom_range(3))
			0: p.inner_protocol = PROTO_ICMP;
			1: p.inner_protocol = PROTO_UDP;
			2: p.inner_protocol = PROTO_TCP;
			default: p.inner_protocol = 8'($urandom());
		endcase
		p.inner_icmp_valid = ($urandom_range(99) < 85);
		case ($urandom_range(4))
			0: p.inner_icmp_type = ICMP_ECHO_REPLY;
			1: p.inner_icmp_type = ICMP_UNREACHABLE;
			2: p.inner_icmp_type = ICMP_REDIR;
			3: p.inner_icmp_type = ICMP_ECHO_REQUEST;
			default: p.inner_icmp_type = 8'($urandom());
		endcase
		r = $urandom_range(99);
		if (r < 4)
			clock_ns = {$urandom(), $urandom()};
		else if (r < 8)
			clock_ns = clock_ns - $urandom_range(1, 2_000_000_000);
		else if (r < 15)
			clock_ns = clock_ns + $urandom_range(500_000_000, 1_500_000_000);
		else
			clock_ns = clock_ns + $urandom_range(0, 80_000_000);
		p.now_ns = clock_ns;
		if ($urandom_range(99) < 10)
			p.cost = 2'($urandom());
		else
			p.cost = 2'($urandom_range(1, 2));
		return p;
	endfunction

	task automatic offer_pkt(pkt_t p);
		while ($urandom_range(99) < send_idle_pct) begin
			pkt_valid <= 1'b0;
			@(posedge clk);
		end
		pkt <= p;
		pkt_valid <= 1'b1;
		do @(posedge clk); while (pkt_ready !== 1'b1);
		pending_verdicts.push_back(rate_filter_verdict(p));
	endtask

	task automatic drain();
		pkt_valid <= 1'b0;
		while (pending_verdicts.size() != 0)
			@(posedge clk);
	endtask

	task automatic set_limits(logic [31:0] key, logic [15:0] lim, logic [15:0] refill);
		cfg_we <= 1'b1;
		cfg_idx <= REG_HASH_KEY;
		cfg_wdata <= key;
		@(posedge clk);
		cfg_idx <= REG_CREDIT_LIMIT;
		cfg_wdata <= {16'd0, lim};
		@(posedge clk);
		cfg_idx <= REG_REFILL_CREDIT;
		cfg_wdata <= {16'd0, refill};
		@(posedge clk);
		cfg_we <= 1'b0;
		key_reg = key;
		limit_reg = lim;
		refill_reg = refill;
	endtask

	task automatic new_src_pool();
		foreach (src_pool[i])
			src_pool[i] = 24'($urandom());
	endtask

	task automatic run_traffic(int n);
		repeat (n)
			offer_pkt(random_icmp_pkt());
		drain();
	endtask

	task automatic test_unchecked_packets();
		pkt_t p;
		p = quoted(icmp_pkt(32'hFFFF_FFFF, ICMP_REDIR, 8'hFF, 64'hFFFF_FFFF_FFFF_FFFF),
			1'b1, PROTO_UDP, 1'b1, 8'hFF);
		p.cost = 2'd3;
		p.outer_valid = 1'b0;
		offer_pkt(p);
		p.outer_valid = 1'b1;
		p.ip_protocol = 8'h00;
		offer_pkt(p);
		p.ip_protocol = 8'hFF;
		offer_pkt(p);
		p.outer_valid = 1'b0;
		p.ip_protocol = PROTO_ICMP;
		offer_pkt(p);
		drain();
	endtask

	task automatic test_first_use_extremes();
		pkt_t p;
		p = icmp_pkt(32'h0000_0000, ICMP_ECHO_REPLY, 8'h00, 64'd0);
		p.cost = 2'd0;
		offer_pkt(p);
		p = icmp_pkt(32'hFFFF_FFFF, ICMP_ECHO_REQUEST, 8'hFF, 64'hFFFF_FFFF_FFFF_FFFF);
		p.cost = 2'd3;
		offer_pkt(p);
		// same prefix, stamp wraps forward by one
		p = icmp_pkt(32'hFFFF_FF00, ICMP_ECHO_REQUEST, 8'h00, 64'd0);
		p.cost = 2'd2;
		offer_pkt(p);
		p = icmp_pkt(32'h0000_0100, ICMP_ECHO_REPLY, 8'h00, 64'd1_000_000_000);
		p.cost = 2'd3;
		offer_pkt(p);
		p.now_ns = 64'd2_600_000_000;
		offer_pkt(p);
		p.src_addr = 32'h0000_00FF;
		p.cost = 2'd0;
		offer_pkt(p);
		drain();
	endtask

	task automatic test_error_filters();
		pkt_t r;
		pkt_t f;
		r = icmp_pkt(32'h0A01_0203, ICMP_REDIR, 8'd1, 64'd10_000_000_000);
		offer_pkt(quoted(r, 1'b1, PROTO_UDP, 1'b0, ICMP_ECHO_REPLY));
		offer_pkt(quoted(r, 1'b1, PROTO_ICMP, 1'b1, ICMP_ECHO_REQUEST));
		offer_pkt(quoted(r, 1'b1, PROTO_TCP, 1'b1, ICMP_ECHO_REPLY));
		offer_pkt(quoted(r, 1'b0, PROTO_UDP, 1'b1, ICMP_ECHO_REPLY));
		f = icmp_pkt(32'h0A01_0304, ICMP_UNREACHABLE, CODE_FRAG_NEEDED, 64'd10_100_000_000);
		offer_pkt(quoted(f, 1'b1, PROTO_ICMP, 1'b1, ICMP_ECHO_REPLY));
		offer_pkt(quoted(f, 1'b1, PROTO_ICMP, 1'b1, ICMP_UNREACHABLE));
		offer_pkt(quoted(f, 1'b1, PROTO_ICMP, 1'b1, ICMP_REDIR));
		offer_pkt(quoted(f, 1'b1, PROTO_ICMP, 1'b1, ICMP_ECHO_REQUEST));
		offer_pkt(quoted(f, 1'b1, PROTO_ICMP, 1'b0, ICMP_ECHO_REPLY));
		offer_pkt(quoted(f, 1'b1, PROTO_UDP, 1'b1, ICMP_ECHO_REPLY));
		f.icmp_code = CODE_PORT_UNREACH;
		offer_pkt(quoted(f, 1'b1, PROTO_ICMP, 1'b1, ICMP_ECHO_REPLY));
		drain();
	endtask

	task automatic test_time_backwards();
		pkt_t p;
		p = icmp_pkt(32'hC0A8_0101, ICMP_ECHO_REQUEST, 8'h00, 64'd3_000_000_000);
		p.cost = 2'd2;
		offer_pkt(p);
		p.now_ns = 64'd3_400_000_000;
		offer_pkt(p);
		p.now_ns = 64'd2_000_000_000;
		offer_pkt(p);
		drain();
	endtask

	task automatic test_tight_buckets();
		set_limits($urandom(), 16'd6, 16'd3);
		new_src_pool();
		send_idle_pct = 0;
		stall_pct = 0;
		run_traffic(300);
	endtask

	task automatic test_no_refill();
		set_limits(32'hFFFF_FFFF, 16'd1, 16'd0);
		new_src_pool();
		send_idle_pct = 75;
		stall_pct = 0;
		run_traffic(300);
	endtask

	task automatic test_wide_buckets();
		set_limits(32'h0000_0000, 16'hFFFF, 16'hFFFF);
		new_src_pool();
		send_idle_pct = 0;
		stall_pct = 75;
		run_traffic(300);
	endtask

	// same key and sources as before, so buckets can start with credit above the new limit
	task automatic test_lowered_limit();
		set_limits(32'h0000_0000, 16'd2, 16'd1);
		send_idle_pct = 25;
		stall_pct = 25;
		run_traffic(300);
	endtask

	task automatic test_backpressure();
		set_limits($urandom(), 16'd20, 16'd5);
		new_src_pool();
		send_idle_pct = 25;
		stall_pct = 25;
		hold_cycles = 400;
		run_traffic(300);
	endtask

	task automatic test_default_rates();
		set_limits($urandom(), CREDIT_LIMIT_RST, REFILL_CREDIT_RST);
		new_src_pool();
		send_idle_pct = 0;
		stall_pct = 0;
		run_traffic(350);
	endtask

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		verdict_ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_cycles > 0) begin
				hold_cycles--;
				verdict_ready <= 1'b0;
			end else begin
				verdict_ready <= ($urandom_range(99) >= stall_pct);
			end
		end
	end

	initial begin
		verdict_t want;
		forever begin
			@(posedge clk);
			if (verdict_valid === 1'b1 && verdict_ready === 1'b1) begin
				if (pending_verdicts.size() == 0) begin
					$error("verdict with nothing pending: %p", verdict);
					mismatch_count++;
				end else begin
					want = pending_verdicts.pop_front();
					if (verdict.drop !== want.drop) begin
						$error("drop: expected %0d, got %0d", want.drop, verdict.drop);
						mismatch_count++;
					end
					if (verdict.verdict_reason !== want.verdict_reason) begin
						$error("verdict_reason: expected %0d, got %0d",
							want.verdict_reason, verdict.verdict_reason);
						mismatch_count++;
					end
					if (verdict.bucket_index !== want.bucket_index) begin
						$error("bucket_index: expected %0d, got %0d",
							want.bucket_index, verdict.bucket_index);
						mismatch_count++;
					end
					if (verdict.credit_left !== want.credit_left) begin
						$error("credit_left: expected %0d, got %0d",
							want.credit_left, verdict.credit_left);
						mismatch_count++;
					end
				end
			end
		end
	end

	initial begin
		#4_000_000;
		$display("CHECK FAILED");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		pkt_valid = 1'b0;
		pkt = '0;
		cfg_we = 1'b0;
		cfg_idx = REG_HASH_KEY;
		cfg_wdata = '0;
		mismatch_count = 0;
		send_idle_pct = 0;
		stall_pct = 0;
		hold_cycles = 0;
		clock_ns = 64'd50_000_000_000;
		key_reg = HASH_KEY_RST;
		limit_reg = CREDIT_LIMIT_RST;
		refill_reg = REFILL_CREDIT_RST;
		foreach (src_pool[i])
			src_pool[i] = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_unchecked_packets();
		test_first_use_extremes();
		test_error_filters();
		test_time_backwards();
		test_tight_buckets();
		test_no_refill();
		test_wide_buckets();
		test_lowered_limit();
		test_backpressure();
		test_default_rates();

		repeat (10) @(posedge clk);
		if (mismatch_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

// ===== icmp_rate_limit_filter.f =====
sv/irlf_pkg.sv
sv/irlf_bucket_ram.sv
sv/irlf_bucket_calc.sv
sv/icmp_rate_limit_filter.sv
tb/icmp_rate_limit_filter_tb.sv
